// ===== rtl/sps_pkg.sv =====
// Shared types, codes and reset values for the slot positioner supervisor.
// No dependencies; compiled first.
package sps_pkg;

  localparam int unsigned MAX_SLOT_DEF = 3;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_POS_PER_SLOT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POS_TOL      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPD_TOL      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MOVE_TMO     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_TMO   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MOVE_SPEED   = 3'd5;

  localparam logic [20:0] POS_PER_SLOT_RST = 21'd128680;
  localparam logic [20:0] POS_TOL_RST      = 21'd3277;
  localparam logic [20:0] SPD_TOL_RST      = 21'd6554;
  localparam logic [15:0] MOVE_TMO_RST     = 16'd5000;
  localparam logic [15:0] ENABLE_TMO_RST   = 16'd500;
  localparam logic [20:0] MOVE_SPEED_RST   = 21'd171573;

  localparam logic [7:0] LAST_SEQ_RST = 8'hFF;

  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_EXECUTE  = 2'd1;
  localparam logic [1:0] CMD_STOP_ALL = 2'd2;
  localparam logic [1:0] CMD_CLEAR    = 2'd3;

  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_ENABLING = 3'd1,
    PH_HOLDING  = 3'd2,
    PH_MOVING   = 3'd3,
    PH_STOPPED  = 3'd4,
    PH_FAULT    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [20:0] position_per_slot;
    logic [20:0] position_tolerance;
    logic [20:0] speed_tolerance;
    logic [15:0] move_timeout_ms;
    logic [15:0] enable_timeout_ms;
    logic [20:0] move_speed;
  } sps_cfg_t;

  typedef struct packed {
    logic               motor_online;
    logic               motor_enable_ack;
    logic signed [31:0] motor_position;
    logic signed [31:0] motor_velocity;
    logic               picture_link_online;
    logic               chassis_link_online;
    logic               chassis_safe_mode;
    logic [1:0]         mechanism_command;
    logic [7:0]         command_seq;
    logic [7:0]         requested_slot;
    logic [31:0]        now_ms;
  } sps_item_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic               send_enable;
    logic               send_disable;
    logic               send_position;
    logic signed [31:0] target_position;
    logic               done_res;
    logic               fault;
    logic [1:0]         slot;
  } sps_res_t;

endpackage

// ===== rtl/sps_if.sv =====
// Valid/ready channel interfaces for control ticks and results.
// Standalone; field widths follow sps_pkg item and result layouts.
interface sps_in_if;
  logic               valid;
  logic               ready;
  logic               motor_online;
  logic               motor_enable_ack;
  logic signed [31:0] motor_position;
  logic signed [31:0] motor_velocity;
  logic               picture_link_online;
  logic               chassis_link_online;
  logic               chassis_safe_mode;
  logic [1:0]         mechanism_command;
  logic [7:0]         command_seq;
  logic [7:0]         requested_slot;
  logic [31:0]        now_ms;

  modport source (
    output valid, motor_online, motor_enable_ack, motor_position, motor_velocity,
           picture_link_online, chassis_link_online, chassis_safe_mode,
           mechanism_command, command_seq, requested_slot, now_ms,
    input  ready
  );
  modport sink (
    input  valid, motor_online, motor_enable_ack, motor_position, motor_velocity,
           picture_link_online, chassis_link_online, chassis_safe_mode,
           mechanism_command, command_seq, requested_slot, now_ms,
    output ready
  );
endinterface

interface sps_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         phase;
  logic               send_enable;
  logic               send_disable;
  logic               send_position;
  logic signed [31:0] target_position;
  logic               done_res;
  logic               fault;
  logic [1:0]         slot;

  modport source (
    output valid, phase, send_enable, send_disable, send_position,
           target_position, done_res, fault, slot,
    input  ready
  );
  modport sink (
    input  valid, phase, send_enable, send_disable, send_position,
           target_position, done_res, fault, slot,
    output ready
  );
endinterface

// ===== rtl/slot_positioner_supervisor.sv =====
// Slot positioner supervisor: top level joining register file and core.
// Depends on sps_pkg, sps_if, sps_regs and sps_core.
//
// Usage: each transaction on in_ch is one control tick (motor feedback,
// link and safety flags, command, sequence number, requested slot and
// millisecond time). Each tick yields exactly one transaction on out_ch
// with the phase, the enable/disable/position strobes, target, done,
// fault and slot as they stand after that tick.
// Path: tick register, then result register, which drives out_ch.valid.
// Throughput: one tick per cycle while out_ch.ready is high; the phase
// update is a single combinational pass between those two registers.
// Stall: while out_ch.ready is low the result holds and one more tick
// is taken into the tick register; in_ch.ready then drops.
// Reset (rst_n low, synchronous): phase wait-feedback, motor not
// enabled, slot 0, last sequence 255, flags and target cleared, and
// the configuration registers return to their defaults.
// Configuration: APB-style writes at byte address 4*index, one per
// access phase; write only while no tick is in flight.
module slot_positioner_supervisor #(
  parameter int unsigned MAX_SLOT = sps_pkg::MAX_SLOT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sps_in_if.sink                         in_ch,
  sps_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sps_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import sps_pkg::*;

  sps_cfg_t cfg;

  sps_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sps_core #(
    .MAX_SLOT (MAX_SLOT)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/sps_regs.sv =====
// APB-style configuration register file for the supervisor.
// Depends on sps_pkg.
module sps_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sps_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output sps_pkg::sps_cfg_t              cfg
);
  import sps_pkg::*;

  sps_cfg_t             cfg_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx        = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.position_per_slot  <= POS_PER_SLOT_RST;
      cfg_r.position_tolerance <= POS_TOL_RST;
      cfg_r.speed_tolerance    <= SPD_TOL_RST;
      cfg_r.move_timeout_ms    <= MOVE_TMO_RST;
      cfg_r.enable_timeout_ms  <= ENABLE_TMO_RST;
      cfg_r.move_speed         <= MOVE_SPEED_RST;
    end else if (wr) begin
      unique case (idx)
        REG_POS_PER_SLOT: cfg_r.position_per_slot  <= cfg_pwdata[20:0];
        REG_POS_TOL:      cfg_r.position_tolerance <= cfg_pwdata[20:0];
        REG_SPD_TOL:      cfg_r.speed_tolerance    <= cfg_pwdata[20:0];
        REG_MOVE_TMO:     cfg_r.move_timeout_ms    <= cfg_pwdata[15:0];
        REG_ENABLE_TMO:   cfg_r.enable_timeout_ms  <= cfg_pwdata[15:0];
        REG_MOVE_SPEED:   cfg_r.move_speed         <= cfg_pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POS_PER_SLOT: cfg_prdata = CFG_DATA_W'(cfg_r.position_per_slot);
      REG_POS_TOL:      cfg_prdata = CFG_DATA_W'(cfg_r.position_tolerance);
      REG_SPD_TOL:      cfg_prdata = CFG_DATA_W'(cfg_r.speed_tolerance);
      REG_MOVE_TMO:     cfg_prdata = CFG_DATA_W'(cfg_r.move_timeout_ms);
      REG_ENABLE_TMO:   cfg_prdata = CFG_DATA_W'(cfg_r.enable_timeout_ms);
      REG_MOVE_SPEED:   cfg_prdata = CFG_DATA_W'(cfg_r.move_speed);
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

// ===== rtl/sps_core.sv =====
// Tick register, phase state update and result register of the supervisor.
// Depends on sps_pkg and the channel interfaces in sps_if.
module sps_core #(
  parameter int unsigned MAX_SLOT = sps_pkg::MAX_SLOT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sps_pkg::sps_cfg_t cfg,
  sps_in_if.sink            in_ch,
  sps_out_if.source         out_ch
);
  import sps_pkg::*;

  localparam int unsigned SLOT_W     = $clog2(MAX_SLOT + 1);
  localparam int unsigned SLOT_EXT_W = (SLOT_W < 2) ? 2 : SLOT_W;

  logic      s1_v_r;
  sps_item_t s1_r;
  logic      out_v_r;
  sps_res_t  out_r;
  logic      move;
  logic      take;

  phase_t              phase_r, phase_nxt;
  logic                en_r, en_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [7:0]          last_seq_r, last_seq_nxt;
  logic                done_r, done_nxt;
  logic                fault_r, fault_nxt;
  logic [31:0]         target_r, target_nxt;
  logic [31:0]         move_start_r, move_start_nxt;
  logic [31:0]         enable_start_r, enable_start_nxt;
  logic                s_en, s_dis, s_pos;
  sps_res_t            res_nxt;

  logic                stop;
  logic                tail;
  logic signed [32:0]  diff;
  logic [32:0]         err_mag;
  logic signed [32:0]  vel_x;
  logic [32:0]         spd_mag;
  logic                arrived;
  logic [31:0]         mv_elapsed;
  logic [SLOT_W-1:0]   slot_clamp;
  logic [SLOT_W+20:0]  prod;
  logic [SLOT_EXT_W-1:0] slot_ext;

  assign move         = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || move;
  assign take         = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (take) begin
      s1_v_r <= 1'b1;
    end else if (move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r.motor_online        <= in_ch.motor_online;
      s1_r.motor_enable_ack    <= in_ch.motor_enable_ack;
      s1_r.motor_position      <= in_ch.motor_position;
      s1_r.motor_velocity      <= in_ch.motor_velocity;
      s1_r.picture_link_online <= in_ch.picture_link_online;
      s1_r.chassis_link_online <= in_ch.chassis_link_online;
      s1_r.chassis_safe_mode   <= in_ch.chassis_safe_mode;
      s1_r.mechanism_command   <= in_ch.mechanism_command;
      s1_r.command_seq         <= in_ch.command_seq;
      s1_r.requested_slot      <= in_ch.requested_slot;
      s1_r.now_ms              <= in_ch.now_ms;
    end
  end

  assign diff       = {s1_r.motor_position[31], s1_r.motor_position}
                    - {target_r[31], target_r};
  assign err_mag    = diff[32] ? 33'(-diff) : 33'(diff);
  assign vel_x      = {s1_r.motor_velocity[31], s1_r.motor_velocity};
  assign spd_mag    = vel_x[32] ? 33'(-vel_x) : 33'(vel_x);
  assign arrived    = (err_mag <= 33'(cfg.position_tolerance))
                   && (spd_mag <= 33'(cfg.speed_tolerance));
  assign mv_elapsed = s1_r.now_ms - move_start_r;
  assign slot_clamp = (s1_r.requested_slot <= 8'(MAX_SLOT)) ?
                      SLOT_W'(s1_r.requested_slot) : SLOT_W'(MAX_SLOT);
  assign prod       = slot_clamp * cfg.position_per_slot;

  assign stop = !s1_r.motor_online || !s1_r.picture_link_online
             || !s1_r.chassis_link_online || s1_r.chassis_safe_mode
             || (s1_r.mechanism_command == CMD_STOP_ALL);

  always_comb begin
    phase_nxt        = phase_r;
    en_nxt           = en_r;
    slot_nxt         = slot_r;
    last_seq_nxt     = last_seq_r;
    done_nxt         = done_r;
    fault_nxt        = fault_r;
    target_nxt       = target_r;
    move_start_nxt   = move_start_r;
    enable_start_nxt = enable_start_r;
    s_en             = 1'b0;
    s_dis            = 1'b0;
    s_pos            = 1'b0;
    tail             = 1'b1;
    if (stop) begin
      if (en_r) begin
        s_dis  = 1'b1;
        en_nxt = 1'b0;
      end
      phase_nxt = s1_r.motor_online ? PH_STOPPED : PH_WAIT;
      done_nxt  = 1'b0;
      tail      = 1'b0;
    end else begin
      if (fault_r && (s1_r.mechanism_command == CMD_CLEAR)) begin
        fault_nxt = 1'b0;
        phase_nxt = PH_ENABLING;
      end
      unique case (phase_nxt)
        PH_WAIT, PH_STOPPED: begin
          phase_nxt = PH_ENABLING;
        end
        PH_ENABLING: begin
          if (!en_r) begin
            s_en             = 1'b1;
            en_nxt           = 1'b1;
            enable_start_nxt = s1_r.now_ms;
            target_nxt       = s1_r.motor_position;
            done_nxt         = 1'b0;
          end
          if (s1_r.motor_enable_ack) begin
            done_nxt  = 1'b1;
            phase_nxt = PH_HOLDING;
          end else if ((s1_r.now_ms - enable_start_nxt) > 32'(cfg.enable_timeout_ms)) begin
            fault_nxt = 1'b1;
            phase_nxt = PH_FAULT;
          end
        end
        PH_HOLDING: begin
          done_nxt = 1'b1;
          if ((s1_r.mechanism_command == CMD_EXECUTE) && (s1_r.command_seq != last_seq_r)) begin
            last_seq_nxt   = s1_r.command_seq;
            slot_nxt       = slot_clamp;
            target_nxt     = 32'(prod);
            move_start_nxt = s1_r.now_ms;
            done_nxt       = 1'b0;
            phase_nxt      = PH_MOVING;
          end
        end
        PH_MOVING: begin
          if (arrived) begin
            done_nxt  = 1'b1;
            phase_nxt = PH_HOLDING;
          end else if (mv_elapsed > 32'(cfg.move_timeout_ms)) begin
            fault_nxt = 1'b1;
            phase_nxt = PH_FAULT;
          end
        end
        default: begin
          if (en_r) begin
            s_dis  = 1'b1;
            en_nxt = 1'b0;
          end
          tail = 1'b0;
        end
      endcase
      s_pos = tail && en_nxt && (phase_nxt != PH_FAULT);
    end
  end

  assign slot_ext = SLOT_EXT_W'(slot_nxt);

  always_comb begin
    res_nxt.phase           = phase_nxt;
    res_nxt.send_enable     = s_en;
    res_nxt.send_disable    = s_dis;
    res_nxt.send_position   = s_pos;
    res_nxt.target_position = target_nxt;
    res_nxt.done_res        = done_nxt;
    res_nxt.fault           = fault_nxt;
    res_nxt.slot            = slot_ext[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_WAIT;
      en_r           <= 1'b0;
      slot_r         <= '0;
      last_seq_r     <= LAST_SEQ_RST;
      done_r         <= 1'b0;
      fault_r        <= 1'b0;
      target_r       <= '0;
      move_start_r   <= '0;
      enable_start_r <= '0;
      out_v_r        <= 1'b0;
    end else begin
      if (move) begin
        phase_r        <= phase_nxt;
        en_r           <= en_nxt;
        slot_r         <= slot_nxt;
        last_seq_r     <= last_seq_nxt;
        done_r         <= done_nxt;
        fault_r        <= fault_nxt;
        target_r       <= target_nxt;
        move_start_r   <= move_start_nxt;
        enable_start_r <= enable_start_nxt;
        out_v_r        <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.phase           = out_r.phase;
  assign out_ch.send_enable     = out_r.send_enable;
  assign out_ch.send_disable    = out_r.send_disable;
  assign out_ch.send_position   = out_r.send_position;
  assign out_ch.target_position = out_r.target_position;
  assign out_ch.done_res        = out_r.done_res;
  assign out_ch.fault           = out_r.fault;
  assign out_ch.slot            = out_r.slot;

endmodule

// ===== test/slot_positioner_supervisor_tb.sv =====
// Self-checking bench for slot_positioner_supervisor: drives control ticks,
// writes the APB registers and checks every status transaction against a
// built-in predictor. Depends on sps_pkg, sps_if and the block's RTL.
`timescale 1ns / 100ps

module slot_positioner_supervisor_tb;
  import sps_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] SLOT_CAP = 8'(MAX_SLOT_DEF);

  class positioner_scoreboard;
    logic [20:0] pitch, pos_tol, spd_tol, move_speed;
    logic [15:0] move_tmo, en_tmo;
    phase_t phase;
    logic enabled, done, fault;
    logic [1:0] slot;
    logic [7:0] last_seq;
    logic signed [31:0] target;
    logic [31:0] move_start, enable_start;
    sps_res_t expected_status[$];
    int errors, reports, ticks, results, arrivals, timeouts, enables;

    function new();
      pitch = POS_PER_SLOT_RST;
      pos_tol = POS_TOL_RST;
      spd_tol = SPD_TOL_RST;
      move_tmo = MOVE_TMO_RST;
      en_tmo = ENABLE_TMO_RST;
      move_speed = MOVE_SPEED_RST;
      phase = PH_WAIT;
      enabled = 1'b0;
      done = 1'b0;
      fault = 1'b0;
      slot = 2'd0;
      last_seq = LAST_SEQ_RST;
      target = '0;
      move_start = '0;
      enable_start = '0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_POS_PER_SLOT: pitch = val[20:0];
        REG_POS_TOL:      pos_tol = val[20:0];
        REG_SPD_TOL:      spd_tol = val[20:0];
        REG_MOVE_TMO:     move_tmo = val[15:0];
        REG_ENABLE_TMO:   en_tmo = val[15:0];
        REG_MOVE_SPEED:   move_speed = val[20:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void note_tick(sps_item_t it);
      sps_res_t r;
      logic s_en, s_dis, s_pos, tail;
      logic [31:0] elapsed;
      longint perr, vmag, tgt_l, ptol_l, stol_l;
      s_en = 1'b0;
      s_dis = 1'b0;
      s_pos = 1'b0;
      tail = 1'b1;
      ticks++;
      if (!it.motor_online || !it.picture_link_online || !it.chassis_link_online ||
          it.chassis_safe_mode || it.mechanism_command == CMD_STOP_ALL) begin
        if (enabled) begin
          s_dis = 1'b1;
          enabled = 1'b0;
        end
        phase = it.motor_online ? PH_STOPPED : PH_WAIT;
        done = 1'b0;
        tail = 1'b0;
      end else begin
        if (fault && it.mechanism_command == CMD_CLEAR) begin
          fault = 1'b0;
          phase = PH_ENABLING;
        end
        case (phase)
          PH_WAIT, PH_STOPPED: phase = PH_ENABLING;
          PH_ENABLING: begin
            if (!enabled) begin
              s_en = 1'b1;
              enabled = 1'b1;
              enable_start = it.now_ms;
              target = it.motor_position;
              done = 1'b0;
              enables++;
            end
            elapsed = it.now_ms - enable_start;
            if (it.motor_enable_ack) begin
              done = 1'b1;
              phase = PH_HOLDING;
            end else if (elapsed > {16'd0, en_tmo}) begin
              fault = 1'b1;
              phase = PH_FAULT;
              timeouts++;
            end
          end
          PH_HOLDING: begin
            done = 1'b1;
            if (it.mechanism_command == CMD_EXECUTE && it.command_seq != last_seq) begin
              last_seq = it.command_seq;
              slot = (it.requested_slot <= SLOT_CAP) ? it.requested_slot[1:0] : SLOT_CAP[1:0];
              target = {11'd0, pitch} * {30'd0, slot};
              move_start = it.now_ms;
              done = 1'b0;
              phase = PH_MOVING;
            end
          end
          PH_MOVING: begin
            tgt_l = target;
            perr = it.motor_position;
            perr = perr - tgt_l;
            if (perr < 0) perr = -perr;
            vmag = it.motor_velocity;
            if (vmag < 0) vmag = -vmag;
            ptol_l = pos_tol;
            stol_l = spd_tol;
            elapsed = it.now_ms - move_start;
            if (perr <= ptol_l && vmag <= stol_l) begin
              done = 1'b1;
              phase = PH_HOLDING;
              arrivals++;
            end else if (elapsed > {16'd0, move_tmo}) begin
              fault = 1'b1;
              phase = PH_FAULT;
              timeouts++;
            end
          end
          default: begin
            if (enabled) begin
              s_dis = 1'b1;
              enabled = 1'b0;
            end
            tail = 1'b0;
          end
        endcase
        if (tail && enabled && phase != PH_FAULT) s_pos = 1'b1;
      end
      r.phase = phase;
      r.send_enable = s_en;
      r.send_disable = s_dis;
      r.send_position = s_pos;
      r.target_position = target;
      r.done_res = done;
      r.fault = fault;
      r.slot = slot;
      expected_status.push_back(r);
    endfunction

    function void check_result(sps_res_t got);
      sps_res_t e;
      results++;
      if (expected_status.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("status transaction %0d arrived with no tick outstanding", results);
        end
        return;
      end
      e = expected_status.pop_front();
      if (got.phase !== e.phase || got.send_enable !== e.send_enable ||
          got.send_disable !== e.send_disable || got.send_position !== e.send_position ||
          got.target_position !== e.target_position || got.done_res !== e.done_res ||
          got.fault !== e.fault || got.slot !== e.slot) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("status %0d expected: phase=%0d en=%b dis=%b pos=%b tgt=%h done=%b flt=%b slot=%0d",
                   results, e.phase, e.send_enable, e.send_disable, e.send_position,
                   e.target_position, e.done_res, e.fault, e.slot);
          $display("status %0d actual:   phase=%0d en=%b dis=%b pos=%b tgt=%h done=%b flt=%b slot=%0d",
                   results, got.phase, got.send_enable, got.send_disable, got.send_position,
                   got.target_position, got.done_res, got.fault, got.slot);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  sps_in_if tick_ch();
  sps_out_if status_ch();

  positioner_scoreboard sb = new();
  int in_idle_pct;
  int out_idle_pct;
  int stall_cycles;
  logic [31:0] clock_ms;

  slot_positioner_supervisor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (tick_ch),
    .out_ch     (status_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    status_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    sps_item_t seen_tick;
    sps_res_t seen_res;
    logic hit;
    hit = 1'b0;
    if (rst_n) begin
      if (tick_ch.valid && tick_ch.ready) begin
        seen_tick.motor_online = tick_ch.motor_online;
        seen_tick.motor_enable_ack = tick_ch.motor_enable_ack;
        seen_tick.motor_position = tick_ch.motor_position;
        seen_tick.motor_velocity = tick_ch.motor_velocity;
        seen_tick.picture_link_online = tick_ch.picture_link_online;
        seen_tick.chassis_link_online = tick_ch.chassis_link_online;
        seen_tick.chassis_safe_mode = tick_ch.chassis_safe_mode;
        seen_tick.mechanism_command = tick_ch.mechanism_command;
        seen_tick.command_seq = tick_ch.command_seq;
        seen_tick.requested_slot = tick_ch.requested_slot;
        seen_tick.now_ms = tick_ch.now_ms;
        sb.note_tick(seen_tick);
        hit = 1'b1;
      end
      if (status_ch.valid && status_ch.ready) begin
        seen_res.phase = status_ch.phase;
        seen_res.send_enable = status_ch.send_enable;
        seen_res.send_disable = status_ch.send_disable;
        seen_res.send_position = status_ch.send_position;
        seen_res.target_position = status_ch.target_position;
        seen_res.done_res = status_ch.done_res;
        seen_res.fault = status_ch.fault;
        seen_res.slot = status_ch.slot;
        sb.check_result(seen_res);
        hit = 1'b1;
      end
      stall_cycles <= hit ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("no transaction for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_tick(input sps_item_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.motor_online <= it.motor_online;
    tick_ch.motor_enable_ack <= it.motor_enable_ack;
    tick_ch.motor_position <= it.motor_position;
    tick_ch.motor_velocity <= it.motor_velocity;
    tick_ch.picture_link_online <= it.picture_link_online;
    tick_ch.chassis_link_online <= it.chassis_link_online;
    tick_ch.chassis_safe_mode <= it.chassis_safe_mode;
    tick_ch.mechanism_command <= it.mechanism_command;
    tick_ch.command_seq <= it.command_seq;
    tick_ch.requested_slot <= it.requested_slot;
    tick_ch.now_ms <= it.now_ms;
    tick_ch.valid <= 1'b1;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [20:0] pitch, input logic [20:0] ptol,
                               input logic [20:0] stol, input logic [15:0] mtmo,
                               input logic [15:0] etmo, input logic [20:0] speed);
    cfg_write(REG_POS_PER_SLOT, {11'd0, pitch});
    cfg_write(REG_POS_TOL, {11'd0, ptol});
    cfg_write(REG_SPD_TOL, {11'd0, stol});
    cfg_write(REG_MOVE_TMO, {16'd0, mtmo});
    cfg_write(REG_ENABLE_TMO, {16'd0, etmo});
    cfg_write(REG_MOVE_SPEED, {11'd0, speed});
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic sps_item_t mk_tick(input logic online, input logic ack,
                                        input logic [1:0] cmd, input logic [7:0] seq,
                                        input logic [7:0] req, input logic [31:0] pos,
                                        input logic [31:0] vel, input logic [31:0] now);
    sps_item_t it;
    it.motor_online = online;
    it.motor_enable_ack = ack;
    it.motor_position = pos;
    it.motor_velocity = vel;
    it.picture_link_online = 1'b1;
    it.chassis_link_online = 1'b1;
    it.chassis_safe_mode = 1'b0;
    it.mechanism_command = cmd;
    it.command_seq = seq;
    it.requested_slot = req;
    it.now_ms = now;
    return it;
  endfunction

  function automatic sps_item_t random_tick();
    sps_item_t it;
    int k, k2;
    logic signed [31:0] off;
    k = $urandom_range(0, 99);
    it.motor_online = 1'b1;
    it.picture_link_online = 1'b1;
    it.chassis_link_online = 1'b1;
    it.chassis_safe_mode = 1'b0;
    if (sb.phase == PH_ENABLING) it.motor_enable_ack = ($urandom_range(0, 99) < 40);
    else it.motor_enable_ack = 1'($urandom_range(0, 1));
    k2 = $urandom_range(0, 99);
    if (sb.fault && k2 < 50) it.mechanism_command = CMD_CLEAR;
    else if (k2 < 45) it.mechanism_command = CMD_NONE;
    else if (k2 < 88) it.mechanism_command = CMD_EXECUTE;
    else if (k2 < 94) it.mechanism_command = CMD_STOP_ALL;
    else it.mechanism_command = CMD_CLEAR;
    k2 = $urandom_range(0, 99);
    if (k2 < 70) it.command_seq = sb.last_seq + 8'd1;
    else if (k2 < 85) it.command_seq = sb.last_seq;
    else it.command_seq = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 75) it.requested_slot = 8'($urandom_range(0, 3));
    else it.requested_slot = 8'($urandom_range(0, 255));
    if (sb.phase == PH_MOVING && $urandom_range(0, 99) < 60) begin
      off = $urandom_range(0, sb.pos_tol + 2);
      if ($urandom_range(0, 1) != 0) off = -off;
      it.motor_position = sb.target + off;
    end else begin
      it.motor_position = $urandom();
    end
    if ($urandom_range(0, 99) < 60) begin
      off = $urandom_range(0, sb.spd_tol + 2);
      if ($urandom_range(0, 1) != 0) off = -off;
      it.motor_velocity = off;
    end else begin
      it.motor_velocity = $urandom();
    end
    k2 = $urandom_range(0, 99);
    if (k2 < 25) clock_ms = clock_ms;
    else if (k2 < 70) clock_ms = clock_ms + $urandom_range(1, 40);
    else if (k2 < 85) clock_ms = clock_ms + $urandom_range(0, 700);
    else if (k2 < 93) clock_ms = clock_ms + $urandom_range(0, 7000);
    else if (k2 < 97 && sb.phase == PH_MOVING)
      clock_ms = sb.move_start + {16'd0, sb.move_tmo} + $urandom_range(0, 1);
    else if (k2 < 97 && sb.phase == PH_ENABLING)
      clock_ms = sb.enable_start + {16'd0, sb.en_tmo} + $urandom_range(0, 1);
    else clock_ms = $urandom();
    it.now_ms = clock_ms;
    if (k < 15) begin
      it.motor_online = ($urandom_range(0, 99) < 70);
      it.motor_enable_ack = 1'($urandom_range(0, 1));
      it.picture_link_online = ($urandom_range(0, 99) < 70);
      it.chassis_link_online = ($urandom_range(0, 99) < 70);
      it.chassis_safe_mode = ($urandom_range(0, 99) < 30);
      it.mechanism_command = 2'($urandom_range(0, 3));
      it.motor_position = $urandom();
    end
    return it;
  endfunction

  initial begin
    sps_item_t t;
    logic [31:0] t0, t1, t2, t3, tgt;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    tick_ch.valid = 1'b0;
    tick_ch.motor_online = 1'b0;
    tick_ch.motor_enable_ack = 1'b0;
    tick_ch.motor_position = '0;
    tick_ch.motor_velocity = '0;
    tick_ch.picture_link_online = 1'b0;
    tick_ch.chassis_link_online = 1'b0;
    tick_ch.chassis_safe_mode = 1'b0;
    tick_ch.mechanism_command = CMD_NONE;
    tick_ch.command_seq = '0;
    tick_ch.requested_slot = '0;
    tick_ch.now_ms = '0;
    status_ch.ready = 1'b0;
    stall_cycles = 0;
    in_idle_pct = 28;
    out_idle_pct = 47;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    t0 = 32'hFFFF_FF00;
    send_tick(mk_tick(1'b0, 1'b0, CMD_NONE, 8'd0, 8'd0, '0, '0, t0));
    send_tick(mk_tick(1'b1, 1'b0, CMD_NONE, 8'd0, 8'd0, 32'h8000_0000, '0, t0));
    send_tick(mk_tick(1'b1, 1'b0, CMD_NONE, 8'd0, 8'd0, 32'h8000_0000, '0, t0));
    send_tick(mk_tick(1'b1, 1'b0, CMD_NONE, 8'd0, 8'd0, '0, '0, t0 + 32'd500));
    send_tick(mk_tick(1'b1, 1'b1, CMD_NONE, 8'd0, 8'd0, '0, '0, t0 + 32'd510));
    send_tick(mk_tick(1'b1, 1'b1, CMD_EXECUTE, 8'hFF, 8'd1, '0, '0, t0 + 32'd520));
    t1 = t0 + 32'd600;
    send_tick(mk_tick(1'b1, 1'b1, CMD_EXECUTE, 8'd0, 8'hFF, '0, '0, t1));
    tgt = 32'd3 * 32'd128680;
    send_tick(mk_tick(1'b1, 1'b1, CMD_NONE, 8'd0, 8'd0, tgt + 32'd3278, '0, t1 + 32'd10));
    send_tick(mk_tick(1'b1, 1'b1, CMD_NONE, 8'd0, 8'd0, tgt + 32'd3277, 32'd6555, t1 + 32'd20));
    send_tick(mk_tick(1'b1, 1'b1, CMD_NONE, 8'd0, 8'd0, tgt - 32'd3277, -32'sd6554,
                      t1 + 32'd30));
    send_tick(mk_tick(1'b1, 1'b1, CMD_EXECUTE, 8'd0, 8'd1, '0, '0, t1 + 32'd40));
    t2 = t1 + 32'd100;
    send_tick(mk_tick(1'b1, 1'b1, CMD_EXECUTE, 8'd1, 8'd1, 32'h7FFF_FFFF, 32'h8000_0000, t2));
    send_tick(mk_tick(1'b1, 1'b1, CMD_NONE, 8'd1, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      t2 + 32'd5000));
    send_tick(mk_tick(1'b1, 1'b1, CMD_NONE, 8'd1, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      t2 + 32'd5001));
    send_tick(mk_tick(1'b1, 1'b1, CMD_NONE, 8'd1, 8'd0, '0, '0, t2 + 32'd5002));
    t3 = t2 + 32'd5100;
    send_tick(mk_tick(1'b1, 1'b0, CMD_CLEAR, 8'd1, 8'd0, 32'hFFFF_FFFF, '0, t3));
    send_tick(mk_tick(1'b1, 1'b0, CMD_NONE, 8'd1, 8'd0, '0, '0, t3 + 32'd501));
    send_tick(mk_tick(1'b1, 1'b0, CMD_STOP_ALL, 8'd1, 8'd0, '0, '0, t3 + 32'd510));
    send_tick(mk_tick(1'b1, 1'b1, CMD_NONE, 8'd1, 8'd0, '0, '0, t3 + 32'd520));
    send_tick(mk_tick(1'b1, 1'b1, CMD_CLEAR, 8'd1, 8'd0, '0, '0, t3 + 32'd530));
    send_tick(mk_tick(1'b1, 1'b1, CMD_CLEAR, 8'd1, 8'd0, '0, '0, t3 + 32'd540));
    t = mk_tick(1'b1, 1'b1, CMD_NONE, 8'd2, 8'd0, '0, '0, t3 + 32'd550);
    t.chassis_safe_mode = 1'b1;
    send_tick(t);
    t = mk_tick(1'b1, 1'b1, CMD_NONE, 8'd2, 8'd0, '0, '0, t3 + 32'd560);
    t.picture_link_online = 1'b0;
    send_tick(t);
    t = mk_tick(1'b1, 1'b1, CMD_NONE, 8'd2, 8'd0, '0, '0, t3 + 32'd570);
    t.chassis_link_online = 1'b0;
    send_tick(t);
    send_tick(mk_tick(1'b0, 1'b1, CMD_EXECUTE, 8'd3, 8'd2, '1, '1, 32'hFFFF_FFFF));
    clock_ms = 32'hFFFF_F000;
    drain();

    load_settings('0, '0, '0, '0, '0, '0);
    repeat (130) send_tick(random_tick());
    drain();

    in_idle_pct = 47;
    out_idle_pct = 28;
    load_settings(21'd1048576, 21'd1048576, 21'd1048576, 16'd65535, 16'd65535, 21'd1048576);
    repeat (130) send_tick(random_tick());
    drain();

    load_settings(21'($urandom_range(0, 1048576)), 21'($urandom_range(0, 20000)),
                  21'($urandom_range(0, 20000)), 16'($urandom_range(1, 3000)),
                  16'($urandom_range(1, 1000)), 21'($urandom_range(0, 1048576)));
    repeat (130) send_tick(random_tick());
    drain();

    in_idle_pct = 0;
    out_idle_pct = 0;
    load_settings(POS_PER_SLOT_RST, POS_TOL_RST, SPD_TOL_RST, MOVE_TMO_RST, ENABLE_TMO_RST,
                  MOVE_SPEED_RST);
    repeat (130) send_tick(random_tick());
    drain();

    $display("Ran %0d control ticks and %0d status transactions over five register settings",
             sb.ticks, sb.results);
    $display("and three idle patterns: %0d motor enables, %0d arrivals, %0d timeout faults.",
             sb.enables, sb.arrivals, sb.timeouts);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d status transactions outstanding", sb.errors, sb.pending());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
